// ===== rtl/core/telematics_frame_builder_bcc_assert.svh =====
// Assertion macros shared by the frame builder RTL.
// Users must have signals named clock and reset in scope.
`ifndef TELEMATICS_FRAME_BUILDER_BCC_ASSERT_SVH
`define TELEMATICS_FRAME_BUILDER_BCC_ASSERT_SVH

// Plain invariant, checked on every edge outside reset.
`define TFB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define TFB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TFB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tfb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the telematics frame builder.
// No dependencies.
package tfb_pkg;

   localparam int ID_BYTES = 17;

   localparam logic [7:0] START_MARK = 8'h23;

   localparam logic ACT_HEADER  = 1'b0;
   localparam logic ACT_PAYLOAD = 1'b1;

   localparam logic [1:0] CSR_ID_LO   = 2'd0;
   localparam logic [1:0] CSR_ID_HI   = 2'd1;
   localparam logic [1:0] CSR_ID_LAST = 2'd2;
   localparam logic [1:0] CSR_ENC     = 2'd3;

   localparam logic [7:0] ENC_RESET = 8'h01;

   // header byte positions: two marks, command, flag, ids, enc, length hi/lo
   localparam int HDR_BYTES   = ID_BYTES + 7;
   localparam int IDX_W       = $clog2(HDR_BYTES + 1);
   localparam logic [IDX_W-1:0] IDX_MARK2   = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_CMD     = IDX_W'(2);
   localparam logic [IDX_W-1:0] IDX_FLAG    = IDX_W'(3);
   localparam logic [IDX_W-1:0] IDX_ID0     = IDX_W'(4);
   localparam logic [IDX_W-1:0] IDX_ENC     = IDX_W'(4 + ID_BYTES);
   localparam logic [IDX_W-1:0] IDX_LEN_HI  = IDX_W'(5 + ID_BYTES);
   localparam logic [IDX_W-1:0] IDX_LEN_LO  = IDX_W'(6 + ID_BYTES);
   localparam logic [IDX_W-1:0] IDX_HCHECK  = IDX_W'(HDR_BYTES);
   localparam logic [IDX_W-1:0] IDX_PCHECK  = IDX_W'(1);

   typedef struct packed {
      logic        action;
      logic [7:0]  command;
      logic [7:0]  response_flag;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_frame;
   } rsp_type;

   // one queued job for the serializer
   typedef struct packed {
      logic        is_hdr;
      logic        closes;   // frame ends with this job: check byte follows
      logic [7:0]  command;
      logic [7:0]  response_flag;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
   } job_type;

endpackage

// ===== rtl/core/tfb_queue.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between the classifier and the serializer.
// Depends on tfb_pkg.
module tfb_queue
   import tfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

`include "telematics_frame_builder_bcc_assert.svh"
   `TFB_ASSERT(a_q_count_bound, count_ff != 2'd3, "job queue count out of range")
   `TFB_ASSERT_IMP(a_q_no_overflow, push, !full, "push into full job queue")
   `TFB_ASSERT_IMP(a_q_no_underflow, pop, head_valid, "pop from empty job queue")

endmodule

// ===== rtl/core/tfb_front.sv =====
`timescale 1ns / 1ps
// Input classifier: tracks the open frame and its byte count, drops stray
// payload beats and queues jobs. Depends on tfb_pkg.
module tfb_front
   import tfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push,
   output job_type push_job,
   input  logic    q_full
);

   logic        open_ff, open_in;
   logic [15:0] left_ff, left_in;
   logic        accept;
   logic        is_hdr;
   logic        pay_ok;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_hdr    = (req_data.action == ACT_HEADER);
   assign pay_ok    = open_ff && (left_ff != 16'd0);

   always_comb begin
      open_in = open_ff;
      left_in = left_ff;
      push    = 1'b0;
      push_job.is_hdr         = is_hdr;
      push_job.command        = req_data.command;
      push_job.response_flag  = req_data.response_flag;
      push_job.payload_length = req_data.payload_length;
      push_job.payload_byte   = req_data.payload_byte;
      push_job.closes         = is_hdr ? (req_data.payload_length == 16'd0)
                                       : (left_ff == 16'd1);
      if (accept) begin
         if (is_hdr) begin
            // a new header abandons whatever frame was open
            push    = 1'b1;
            left_in = req_data.payload_length;
            open_in = (req_data.payload_length != 16'd0);
         end else if (pay_ok) begin
            push    = 1'b1;
            left_in = left_ff - 16'd1;
            open_in = (left_ff != 16'd1);
         end else begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= 16'd0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
   end

`include "telematics_frame_builder_bcc_assert.svh"
   `TFB_ASSERT_IMP(a_front_open_count, open_ff, left_ff != 16'd0,
                   "open frame with no bytes left")

endmodule

// ===== rtl/core/tfb_back.sv =====
`timescale 1ns / 1ps
// Serializer: expands queued jobs into frame bytes, keeps the XOR check and
// the configuration registers, and drives the output register. Depends on tfb_pkg.
module tfb_back
   import tfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   logic [63:0]       id_lo_ff;
   logic [63:0]       id_hi_ff;
   logic [7:0]        id_last_ff;
   logic [7:0]        enc_ff;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        check_ff, check_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [135:0]      id_vec;
   logic [IDX_W-1:0]  id_sel;
   logic [7:0]        byte_val;
   logic              is_check;
   logic              is_last;
   logic              advance;

   assign id_vec = {id_last_ff, id_hi_ff, id_lo_ff};
   assign id_sel = idx_ff - IDX_ID0;

   always_comb begin
      if (head_job.is_hdr) begin
         is_check = (idx_ff == IDX_HCHECK);
         is_last  = head_job.closes ? (idx_ff == IDX_HCHECK) : (idx_ff == IDX_LEN_LO);
      end else begin
         is_check = (idx_ff == IDX_PCHECK);
         is_last  = head_job.closes ? (idx_ff == IDX_PCHECK) : 1'b1;
      end
   end

   always_comb begin
      if (is_check) begin
         byte_val = check_ff;
      end else if (!head_job.is_hdr) begin
         byte_val = head_job.payload_byte;
      end else if (idx_ff <= IDX_MARK2) begin
         byte_val = START_MARK;
      end else if (idx_ff == IDX_CMD) begin
         byte_val = head_job.command;
      end else if (idx_ff == IDX_FLAG) begin
         byte_val = head_job.response_flag;
      end else if (idx_ff < IDX_ENC) begin
         byte_val = id_vec[{id_sel, 3'b000} +: 8];
      end else if (idx_ff == IDX_ENC) begin
         byte_val = enc_ff;
      end else if (idx_ff == IDX_LEN_HI) begin
         byte_val = head_job.payload_length[15:8];
      end else begin
         byte_val = head_job.payload_length[7:0];
      end
   end

   // output register takes a new byte whenever it is empty or being drained
   assign advance = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop     = advance && is_last;

   always_comb begin
      idx_in       = idx_ff;
      check_in     = check_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         idx_in                   = is_last ? '0 : idx_ff + IDX_W'(1);
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_byte     = byte_val;
         rsp_data_in.last_of_run  = is_last;
         rsp_data_in.end_of_frame = is_check;
         // start marks are left out of the check
         if (head_job.is_hdr && idx_ff == '0) begin
            check_in = 8'h00;
         end else if (!is_check && !(head_job.is_hdr && idx_ff == IDX_MARK2)) begin
            check_in = check_ff ^ byte_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         check_ff     <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_lo_ff   <= 64'd0;
         id_hi_ff   <= 64'd0;
         id_last_ff <= 8'd0;
         enc_ff     <= ENC_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ID_LO:   id_lo_ff   <= csr_wdata;
            CSR_ID_HI:   id_hi_ff   <= csr_wdata;
            CSR_ID_LAST: id_last_ff <= csr_wdata[7:0];
            CSR_ENC:     enc_ff     <= csr_wdata[7:0];
            default:     ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "telematics_frame_builder_bcc_assert.svh"
   `TFB_ASSERT_IMP(a_back_job_held, idx_ff != '0, head_valid,
                   "serializer mid-job with no job at queue head")
   `TFB_ASSERT_IMP(a_back_eof_last, rsp_valid_ff && rsp_data_ff.end_of_frame,
                   rsp_data_ff.last_of_run, "check beat not last of its run")

endmodule

// ===== rtl/core/telematics_frame_builder_bcc.sv =====
`timescale 1ns / 1ps
// Top level of the telematics frame builder with XOR block check.
// Depends on tfb_pkg, tfb_front, tfb_queue, tfb_back.
//
//   channel   handshake             payload
//   req       req_valid/req_ready   req_data  (req_type)
//   rsp       rsp_valid/rsp_ready   rsp_data  (rsp_type)
//   csr       csr_we                csr_index, csr_wdata
//
// One output beat per cycle while rsp_ready is high and a job is queued: a payload
// beat gives one byte (two when it closes the frame), a header gives ID_BYTES+7
// bytes (one more for zero length), all from the single-byte serializer.
// A two-entry job queue lets payload beats stream one per cycle; req stalls
// while both entries are taken, e.g. behind a header burst or rsp_ready low.
// Stray payload beats are consumed with no output.
// Synchronous reset clears all control state; no clearing pass is needed.
module telematics_frame_builder_bcc
   import tfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic    push;
   job_type push_job;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   tfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_job  (push_job),
      .q_full    (q_full)
   );

   tfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the telematics frame builder: random header and payload
// beats against an in-bench frame predictor. Depends on tfb_pkg and the block RTL.
module tb_top;
   import tfb_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_ID_LO;
   logic [63:0] csr_wdata = '0;

   // predictor state and register copies
   logic [63:0] cfg_id_lo = '0;
   logic [63:0] cfg_id_hi = '0;
   logic [7:0]  cfg_id_last = '0;
   logic [7:0]  cfg_enc = ENC_RESET;
   logic [7:0]  chk_acc = '0;
   logic [15:0] left_cnt = '0;
   bit          open_frame = 1'b0;

   req_type stim_q[$];
   rsp_type frame_bytes_q[$];
   rsp_type want;

   int  fail_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_trigger = 1'b0;
   bit  hold_done = 1'b0;
   bit  quiet = 1'b0;

   telematics_frame_builder_bcc i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic rsp_type mk_beat(input logic [7:0] b, input logic eof);
      rsp_type r;
      r.out_byte = b;
      r.last_of_run = 1'b0;
      r.end_of_frame = eof;
      return r;
   endfunction

   // expected beats caused by one accepted request beat
   task automatic frame_predict(input req_type item);
      rsp_type      run_beats[$];
      logic [7:0]   hdr_bytes[ID_BYTES + 5];
      logic [135:0] id_all;
      id_all = {cfg_id_last, cfg_id_hi, cfg_id_lo};
      if (item.action == ACT_HEADER) begin
         hdr_bytes[0] = item.command;
         hdr_bytes[1] = item.response_flag;
         for (int k = 0; k < ID_BYTES; k++) hdr_bytes[k + 2] = id_all[8*k +: 8];
         hdr_bytes[ID_BYTES + 2] = cfg_enc;
         hdr_bytes[ID_BYTES + 3] = item.payload_length[15:8];
         hdr_bytes[ID_BYTES + 4] = item.payload_length[7:0];
         run_beats.insert(run_beats.size(), mk_beat(START_MARK, 1'b0));
         run_beats.insert(run_beats.size(), mk_beat(START_MARK, 1'b0));
         chk_acc = '0;
         foreach (hdr_bytes[i]) begin
            chk_acc ^= hdr_bytes[i];
            run_beats.insert(run_beats.size(), mk_beat(hdr_bytes[i], 1'b0));
         end
         left_cnt = item.payload_length;
         open_frame = (left_cnt != 0);
         if (!open_frame)
            run_beats.insert(run_beats.size(), mk_beat(chk_acc, 1'b1));
      end else if (open_frame && left_cnt != 0) begin
         chk_acc ^= item.payload_byte;
         run_beats.insert(run_beats.size(), mk_beat(item.payload_byte, 1'b0));
         left_cnt--;
         if (left_cnt == 0) begin
            run_beats.insert(run_beats.size(), mk_beat(chk_acc, 1'b1));
            open_frame = 1'b0;
         end
      end else begin
         open_frame = 1'b0;
      end
      if (run_beats.size() != 0) begin
         run_beats[run_beats.size() - 1].last_of_run = 1'b1;
         foreach (run_beats[i]) frame_bytes_q.insert(frame_bytes_q.size(), run_beats[i]);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (stim_q.size() != 0) begin
            req_data <= stim_q.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 11);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predicts on accepted requests, checks accepted responses, drives rsp_ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) frame_predict(req_data);
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_q.size() == 0) begin
               $error("unexpected beat: out_byte %h last_of_run %b end_of_frame %b",
                      rsp_data.out_byte, rsp_data.last_of_run, rsp_data.end_of_frame);
               fail_count++;
            end else begin
               want = frame_bytes_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b", want.last_of_run,
                         rsp_data.last_of_run);
                  fail_count++;
               end
               if (rsp_data.end_of_frame !== want.end_of_frame) begin
                  $error("end_of_frame: expected %b, got %b", want.end_of_frame,
                         rsp_data.end_of_frame);
                  fail_count++;
               end
            end
         end
         if (hold_trigger && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 11);
         end
      end
   end

   task automatic queue_header(input logic [7:0] cmd, input logic [7:0] flag,
                               input logic [15:0] len);
      req_type it;
      it.action = ACT_HEADER;
      it.command = cmd;
      it.response_flag = flag;
      it.payload_length = len;
      it.payload_byte = 8'($urandom);
      stim_q.insert(stim_q.size(), it);
   endtask

   task automatic queue_payload(input logic [7:0] data_byte);
      req_type it;
      it.action = ACT_PAYLOAD;
      it.command = 8'($urandom);
      it.response_flag = 8'($urandom);
      it.payload_length = 16'($urandom);
      it.payload_byte = data_byte;
      stim_q.insert(stim_q.size(), it);
   endtask

   // mostly complete frames, some cut short by a new header, some stray payload
   task automatic queue_traffic(input int n_items);
      int made;
      int sel;
      int len;
      int cut;
      made = 0;
      while (made < n_items) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            queue_header(8'($urandom), 8'($urandom), 16'(len));
            repeat (len) queue_payload(8'($urandom));
            made += 1 + len;
         end else if (sel < 85) begin
            len = $urandom_range(0, 65535);
            cut = $urandom_range(0, 3);
            if (cut > len) cut = len;
            queue_header(8'($urandom), 8'($urandom), 16'(len));
            repeat (cut) queue_payload(8'($urandom));
            made += 1 + cut;
         end else begin
            cut = $urandom_range(1, 3);
            repeat (cut) queue_payload(8'($urandom));
            made += cut;
         end
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ID_LO:   cfg_id_lo = val;
         CSR_ID_HI:   cfg_id_hi = val;
         CSR_ID_LAST: cfg_id_last = val[7:0];
         CSR_ENC:     cfg_enc = val[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic csr_write_all(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [7:0] last, input logic [7:0] enc);
      csr_write(CSR_ID_LO, lo);
      csr_write(CSR_ID_HI, hi);
      csr_write(CSR_ID_LAST, {56'($urandom), last});
      csr_write(CSR_ENC, {56'($urandom), enc});
   endtask

   // sender pause: nothing queued, nothing in flight, nothing owed
   task automatic wait_idle(input int settle);
      do @(negedge clock);
      while (stim_q.size() != 0 || req_valid || frame_bytes_q.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset register values: ids zero, encryption byte one
      queue_payload(8'hFF);                 // stray, no frame open yet
      queue_header(8'hFF, 8'h00, 16'd0);    // zero length, check follows header
      queue_header(8'h00, 8'hFF, 16'd2);
      queue_payload(8'hFF);
      queue_payload(8'h00);
      queue_payload(8'h5A);                 // stray after a closed frame
      queue_header(8'hA5, 8'h5A, 16'd3);
      queue_payload(8'h01);
      queue_header(8'h3C, 8'hC3, 16'hFFFF); // abandons the open frame
      queue_payload(8'h80);
      queue_header(8'h7F, 8'h80, 16'h8000);
      queue_header(8'h01, 8'hFE, 16'd1);
      queue_payload(8'h23);
      wait_idle(SETTLE_CYCLES);

      csr_write_all('1, '1, 8'hFF, 8'hFF);
      queue_header(8'hFF, 8'hFF, 16'd0);
      queue_header(8'h00, 8'h00, 16'd1);
      queue_payload(8'hFF);
      queue_header(8'h55, 8'hAA, 16'h0100);
      queue_payload(8'h00);
      wait_idle(SETTLE_CYCLES);

      csr_write_all('0, '0, 8'h00, 8'h00);
      queue_traffic(90);
      hold_trigger = 1'b1;                  // long receiver stall with the sender busy
      wait_idle(SETTLE_CYCLES);

      csr_write_all({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 8'($urandom));
      queue_traffic(40);
      wait_idle(0);
      queue_traffic(40);
      wait_idle(SETTLE_CYCLES);

      csr_write_all({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 8'($urandom));
      queue_traffic(90);
      wait_idle(SETTLE_CYCLES);

      csr_write_all({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 8'($urandom));
      quiet = 1'b1;
      queue_traffic(90);
      wait_idle(SETTLE_CYCLES);

      if (fail_count == 0 && frame_bytes_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
